### hw/rtl/csed_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csed_pkg
// Types, character codes and the named-escape lookup shared by the string
// escape decoder modules.
// ----------------------------------------------------------------------------
package csed_pkg;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_SEVEN     = 8'h37;
  localparam logic [1:0] MAX_DIGITS   = 2'd3;

  // Result kinds
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Most results a single input byte can cause
  localparam int unsigned MAX_RESULTS = 3;

  typedef struct packed {
    logic [7:0] ch;
    logic       final_char;
  } csed_in_t;

  typedef struct packed {
    logic       out_kind;
    logic [7:0] out_byte;
    logic       last;
  } csed_out_t;

  typedef struct packed {
    logic       in_escape;
    logic [1:0] digit_count;
    logic [7:0] octal_accum;
  } csed_state_t;

  // Results of one input byte, slot 0 first
  typedef struct packed {
    csed_out_t [MAX_RESULTS-1:0] res;
    logic [1:0]                  count;
  } csed_batch_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] code;
  } csed_named_t;

  function automatic csed_named_t named_code(input logic [7:0] c);
    csed_named_t r;
    r.hit = 1'b1;
    case (c)
      8'h61:        r.code = 8'd7;   // a
      8'h62:        r.code = 8'd8;   // b
      8'h66:        r.code = 8'd12;  // f
      8'h6E:        r.code = 8'd10;  // n
      8'h72:        r.code = 8'd13;  // r
      8'h74:        r.code = 8'd9;   // t
      8'h76:        r.code = 8'd11;  // v
      CH_QUOTE:     r.code = CH_QUOTE;
      CH_BACKSLASH: r.code = CH_BACKSLASH;
      default: begin
        r.hit  = 1'b0;
        r.code = 8'd0;
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/csed_decode.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csed_decode
// Decodes one string byte against the escape state: gives the next state and
// up to three results, in order, with last set on the final one.
// ----------------------------------------------------------------------------
module csed_decode import csed_pkg::*; (
  input  wire csed_in_t    item_i,
  input  wire csed_state_t state_i,
  output csed_state_t      state_o,
  output csed_batch_t      batch_o
);

  csed_named_t named;

  always_comb begin
    csed_state_t                 st;
    csed_out_t [MAX_RESULTS-1:0] res;
    logic [1:0]                  n;
    logic                        plain;
    logic                        ended;
    logic [7:0]                  acc_nxt;
    logic [1:0]                  dc_nxt;

    st      = state_i;
    res     = '0;
    n       = 2'd0;
    plain   = 1'b0;
    ended   = 1'b0;
    named   = named_code(item_i.ch);
    acc_nxt = {state_i.octal_accum[4:0], item_i.ch[2:0]};
    dc_nxt  = state_i.digit_count + 2'd1;

    if (!state_i.in_escape) begin
      plain = 1'b1;
    end else if (state_i.digit_count == 2'd0 && named.hit) begin
      res[n] = '{out_kind: KIND_DATA, out_byte: named.code, last: 1'b0};
      n      = n + 2'd1;
      st     = '0;
    end else if (item_i.ch inside {[CH_ZERO:CH_SEVEN]}) begin
      st.octal_accum = acc_nxt;
      st.digit_count = dc_nxt;
      if (dc_nxt == MAX_DIGITS) begin
        res[n] = '{out_kind: KIND_DATA, out_byte: acc_nxt, last: 1'b0};
        n      = n + 2'd1;
        st     = '0;
      end
    end else begin
      // flush the partial value, then treat the byte as plain
      res[n] = '{out_kind: KIND_DATA, out_byte: state_i.octal_accum, last: 1'b0};
      n      = n + 2'd1;
      st     = '0;
      plain  = 1'b1;
    end

    if (plain) begin
      if (item_i.ch == CH_QUOTE) begin
        res[n] = '{out_kind: KIND_END, out_byte: 8'd0, last: 1'b0};
        n      = n + 2'd1;
        ended  = 1'b1;
        st     = '0;
      end else if (item_i.ch == CH_BACKSLASH) begin
        st.in_escape   = 1'b1;
        st.digit_count = 2'd0;
        st.octal_accum = 8'd0;
      end else begin
        res[n] = '{out_kind: KIND_DATA, out_byte: item_i.ch, last: 1'b0};
        n      = n + 2'd1;
      end
    end

    // drop any pending escape and give an end marker at buffer end
    if (item_i.final_char && !ended) begin
      st     = '0;
      res[n] = '{out_kind: KIND_END, out_byte: 8'd0, last: 1'b0};
      n      = n + 2'd1;
    end

    for (int i = 0; i < MAX_RESULTS; i++) begin
      res[i].last = (n != 2'd0) && (2'(i) == n - 2'd1);
    end

    state_o       = st;
    batch_o.res   = res;
    batch_o.count = n;
  end

endmodule

`default_nettype wire

### hw/rtl/csed_result_buf.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csed_result_buf
// Result register for the decoder: holds the results of one byte and hands
// them out one transfer at a time.
// ----------------------------------------------------------------------------
module csed_result_buf import csed_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        load_i,
  input  wire csed_batch_t batch_i,
  output logic             ready_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output csed_out_t        out_data_o
);

  csed_out_t [MAX_RESULTS-1:0] res_q;
  logic [1:0]                  idx_q, idx_d;
  logic [1:0]                  rem_q, rem_d;
  logic                        pop;

  assign out_valid_o = (rem_q != 2'd0);
  assign pop         = out_valid_o && !out_stall_i;
  assign ready_o     = (rem_q == 2'd0) || (rem_q == 2'd1 && pop);

  always_comb begin
    case (idx_q)
      2'd1:    out_data_o = res_q[1];
      2'd2:    out_data_o = res_q[2];
      default: out_data_o = res_q[0];
    endcase
  end

  always_comb begin
    idx_d = idx_q;
    rem_d = rem_q;
    if (load_i) begin
      idx_d = 2'd0;
      rem_d = batch_i.count;
    end else if (pop) begin
      // advance to the next result of this byte
      idx_d = idx_q + 2'd1;
      rem_d = rem_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
      rem_q <= 2'd0;
    end else begin
      idx_q <= idx_d;
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= batch_i.res;
    end
  end

  a_within_buf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, idx_q} + {1'b0, rem_q}) <= 3'd3)
    else $error("result pointer runs past the buffer");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> (rem_q == 2'd0 || (rem_q == 2'd1 && pop)))
    else $error("results overwritten before transfer");

  a_last_on_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && rem_q == 2'd1) |-> out_data_o.last)
    else $error("final result of a byte lacks last");

  a_no_early_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && rem_q != 2'd1) |-> !out_data_o.last)
    else $error("last set before the final result of a byte");

endmodule

`default_nettype wire

### hw/rtl/c_string_escape_decoder_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c_string_escape_decoder_core
// Decodes the body of a double-quoted C-style string, one byte per transfer,
// into data bytes and end-of-string markers.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i / in_stall_o   csed_in_t  (ch, final_char)
//   out      output     out_valid_o / out_stall_i csed_out_t (out_kind,
//                                                   out_byte, last)
//
// A byte is registered on transfer and decoded from that register; its
// results load into the result register once it can take them. One byte
// per cycle while each byte gives at most one result and the output is not
// stalled; more results of a byte hold the input at the single output port.
// Reset clears the escape state and both valid flags; no clearing pass.
// Output stall backs up through the result register to in_stall_o.
// ----------------------------------------------------------------------------
module c_string_escape_decoder_core import csed_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire csed_in_t in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output csed_out_t     out_data_o
);

  csed_in_t    in_q;
  logic        in_vld_q, in_vld_d;
  csed_state_t state_q, state_d;
  csed_batch_t batch;
  logic        buf_ready;
  logic        advance;
  logic        accept;

  assign advance    = in_vld_q && buf_ready;
  assign in_stall_o = in_vld_q && !buf_ready;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (accept) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      state_q  <= '0;
    end else begin
      in_vld_q <= in_vld_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
  end

  csed_decode u_decode (
    .item_i  (in_q),
    .state_i (state_q),
    .state_o (state_d),
    .batch_o (batch)
  );

  csed_result_buf u_result_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .batch_i     (batch),
    .ready_o     (buf_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

### dv/csed_decode_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csed_decode_monitor
// Watches both channels of the string escape decoder, decodes every accepted
// input byte with its own escape state and compares each result transfer,
// field by field, with the oldest decoded result still waiting.
// ----------------------------------------------------------------------------
module csed_decode_monitor import csed_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  csed_in_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  csed_out_t   out_data_i,
  output int unsigned mismatch_cnt_o,
  output int unsigned pending_cnt_o,
  output int unsigned result_cnt_o
);

  csed_state_t dec_state;
  csed_out_t   decoded_bytes[$];
  csed_out_t   step_results[$];

  function automatic logic named_escape(input logic [7:0] c, output logic [7:0] code);
    named_escape = 1'b1;
    case (c)
      8'h61:        code = 8'h07;  // a
      8'h62:        code = 8'h08;  // b
      8'h66:        code = 8'h0C;  // f
      8'h6E:        code = 8'h0A;  // n
      8'h72:        code = 8'h0D;  // r
      8'h74:        code = 8'h09;  // t
      8'h76:        code = 8'h0B;  // v
      CH_QUOTE:     code = CH_QUOTE;
      CH_BACKSLASH: code = CH_BACKSLASH;
      default: begin
        named_escape = 1'b0;
        code         = 8'h00;
      end
    endcase
  endfunction

  function automatic void emit_result(input logic kind, input logic [7:0] value);
    csed_out_t r;
    r.out_kind = kind;
    r.out_byte = value;
    r.last     = 1'b0;
    step_results.push_back(r);
  endfunction

  function automatic void decode_byte(input csed_in_t item);
    logic       plain;
    logic       ended;
    logic       hit;
    logic [7:0] code;
    plain = 1'b0;
    ended = 1'b0;
    step_results.delete();
    if (!dec_state.in_escape) begin
      plain = 1'b1;
    end else begin
      // named escapes count only right after the backslash
      hit = named_escape(item.ch, code);
      if (dec_state.digit_count != 2'd0) hit = 1'b0;
      if (hit) begin
        emit_result(KIND_DATA, code);
        dec_state = '0;
      end else if (item.ch >= CH_ZERO && item.ch <= CH_SEVEN) begin
        dec_state.octal_accum = {dec_state.octal_accum[4:0], item.ch[2:0]};
        dec_state.digit_count = dec_state.digit_count + 2'd1;
        if (dec_state.digit_count == MAX_DIGITS) begin
          emit_result(KIND_DATA, dec_state.octal_accum);
          dec_state = '0;
        end
      end else begin
        // interrupted escape: flush the value, then treat the byte as plain
        emit_result(KIND_DATA, dec_state.octal_accum);
        dec_state = '0;
        plain     = 1'b1;
      end
    end
    if (plain) begin
      if (item.ch == CH_QUOTE) begin
        emit_result(KIND_END, 8'h00);
        ended     = 1'b1;
        dec_state = '0;
      end else if (item.ch == CH_BACKSLASH) begin
        dec_state           = '0;
        dec_state.in_escape = 1'b1;
      end else begin
        emit_result(KIND_DATA, item.ch);
      end
    end
    // drop any pending escape and give an end marker at buffer end
    if (item.final_char && !ended) begin
      dec_state = '0;
      emit_result(KIND_END, 8'h00);
    end
    if (step_results.size() > 0) step_results[step_results.size()-1].last = 1'b1;
    foreach (step_results[k]) decoded_bytes.push_back(step_results[k]);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    csed_out_t want;
    logic      bad;
    if (!rst_ni) begin
      dec_state = '0;
      decoded_bytes.delete();
      mismatch_cnt_o = 0;
      result_cnt_o   = 0;
      pending_cnt_o  = 0;
    end else begin
      // compare first: a result never belongs to a byte taken at this edge
      if (out_valid_i && !out_stall_i) begin
        result_cnt_o = result_cnt_o + 1;
        if (decoded_bytes.size() == 0) begin
          $display("%0t: unexpected result expected none actual kind %0d byte 0x%02h last %0d",
                   $time, out_data_i.out_kind, out_data_i.out_byte, out_data_i.last);
          mismatch_cnt_o = mismatch_cnt_o + 1;
        end else begin
          want = decoded_bytes.pop_front();
          bad  = 1'b0;
          if (out_data_i.out_kind !== want.out_kind) begin
            $display("%0t: out_kind expected %0d actual %0d",
                     $time, want.out_kind, out_data_i.out_kind);
            bad = 1'b1;
          end
          if (out_data_i.out_byte !== want.out_byte) begin
            $display("%0t: out_byte expected 0x%02h actual 0x%02h",
                     $time, want.out_byte, out_data_i.out_byte);
            bad = 1'b1;
          end
          if (out_data_i.last !== want.last) begin
            $display("%0t: last expected %0d actual %0d", $time, want.last, out_data_i.last);
            bad = 1'b1;
          end
          if (bad) mismatch_cnt_o = mismatch_cnt_o + 1;
        end
      end
      if (in_valid_i && !in_stall_i) decode_byte(in_data_i);
      pending_cnt_o = decoded_bytes.size();
    end
  end

endmodule

### dv/c_string_escape_decoder_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_string_escape_decoder_core_tb
// Feeds string bodies to the escape decoder: a directed set of edge cases,
// then random strings built from plain bytes, named and octal escapes, broken
// escapes and noise, under several mixes of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module c_string_escape_decoder_core_tb;
  import csed_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 460;
  localparam int PHASES       = 5;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  csed_in_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  csed_out_t   out_data;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned results_seen;
  int          cycle_cnt   = 0;
  int          bytes_sent  = 0;
  int          in_pace     = 0;
  int          out_pace    = 0;

  logic [7:0] named_chars [9] = '{8'h61, 8'h62, 8'h66, 8'h6E, 8'h72, 8'h74, 8'h76,
                                  CH_QUOTE, CH_BACKSLASH};

  always #10 clk = ~clk;

  c_string_escape_decoder_core i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  csed_decode_monitor i_monitor (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .in_data_i      (in_data),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .out_data_i     (out_data),
    .mismatch_cnt_o (mismatches),
    .pending_cnt_o  (outstanding),
    .result_cnt_o   (results_seen)
  );

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // pace 0: no gaps, 1: occasional gaps, 2: a random gap, possibly none, before each item
  function automatic int draw_wait(input int pace);
    case (pace)
      0:       draw_wait = 0;
      1:       draw_wait = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
      default: draw_wait = $urandom_range(0, 16);
    endcase
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE || c == CH_BACKSLASH);
    plain_byte = c;
  endfunction

  // Returns at the edge where the byte transfers
  task automatic send_byte(input logic [7:0] c, input logic fin);
    csed_in_t item;
    int       gap;
    item.ch         = c;
    item.final_char = fin;
    gap             = draw_wait(in_pace);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall !== 1'b0);
    bytes_sent++;
  endtask

  task automatic send_text(input string s, input logic fin_last);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i], fin_last && (i == s.len() - 1));
  endtask

  // Hold the input until every decoded result has transferred
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  task automatic send_random_string();
    int n_tok;
    int kind;
    int n_dig;
    int t;
    int d;
    n_tok = $urandom_range(1, 8);
    for (t = 0; t < n_tok; t++) begin
      kind = $urandom_range(0, 9);
      if (kind <= 3) begin
        send_byte(plain_byte(), 1'b0);
      end else if (kind <= 5) begin
        send_byte(CH_BACKSLASH, 1'b0);
        send_byte(named_chars[$urandom_range(0, 8)], 1'b0);
      end else if (kind <= 7) begin
        send_byte(CH_BACKSLASH, 1'b0);
        n_dig = $urandom_range(1, 3);
        for (d = 0; d < n_dig; d++) send_byte(CH_ZERO + 8'($urandom_range(0, 7)), 1'b0);
      end else if (kind == 8) begin
        send_byte(CH_BACKSLASH, 1'b0);
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
      end else begin
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
      end
    end
    case ($urandom_range(0, 4))
      0, 1:    send_byte(CH_QUOTE, $urandom_range(0, 3) == 0);
      2:       send_byte(plain_byte(), 1'b1);
      3:       send_byte(CH_ZERO + 8'($urandom_range(0, 7)), 1'b1);
      default: ;  // run on into the next string
    endcase
  endtask

  initial begin : result_sink
    int hold;
    forever begin
      hold = draw_wait(out_pace);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  initial begin : stimulus
    int directed;
    int p;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    in_pace  = 1;
    out_pace = 1;
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text("\\n", 1'b0);
    send_text("\\\\", 1'b0);
    send_text("\\777", 1'b0);   // wraps to 0xFF
    send_text("\\1n", 1'b0);    // named letter after a digit ends the escape
    send_text("\\2\\8", 1'b0);  // backslash then non-octal digit interrupt
    send_text("\\q", 1'b1);     // flush, plain byte and end marker
    send_text("\\1", 1'b1);     // partial escape dropped
    send_text("\"", 1'b1);      // quote on the final byte
    send_text("\\5\"", 1'b0);
    send_text("\\", 1'b1);
    wait_drained();
    directed = bytes_sent;

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0:       begin in_pace = 0; out_pace = 0; end
        1:       begin in_pace = 2; out_pace = 0; end
        2:       begin in_pace = 0; out_pace = 2; end
        3:       begin in_pace = 2; out_pace = 2; end
        default: begin in_pace = 1; out_pace = 1; end
      endcase
      while (bytes_sent < directed + (p + 1) * RANDOM_ITEMS / PHASES) send_random_string();
      wait_drained();
    end

    repeat (10) @(posedge clk);
    $display("Covered %0d input transfers and %0d result transfers", bytes_sent, results_seen);
    $display("Mix: named, octal, interrupted and truncated escapes under five pacing mixes");
    if (mismatches == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/csed_pkg.sv
hw/rtl/csed_decode.sv
hw/rtl/csed_result_buf.sv
hw/rtl/c_string_escape_decoder_core.sv
dv/csed_decode_monitor.sv
dv/c_string_escape_decoder_core_tb.sv
